// File: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants for the line rasterizer: default coordinate width,
// item kind codes and the depth of the command queue.
// ----------------------------------------------------------------------------
package blr_pkg;

	// default width of one coordinate
	localparam int COORD_BITS_DEF = 16;

	// depth of the queue between decode and stepping
	localparam int QUEUE_DEPTH = 2;

	// item kind codes
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

endpackage

// File: rtl/blr_if.sv
// ----------------------------------------------------------------------------
// blr_if
// Valid/ready channels of the line rasterizer: the item channel that
// carries start and step items, and the pixel channel.
// ----------------------------------------------------------------------------
interface blr_in_if #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blr_out_if #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// File: rtl/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front
// Decode stage: accepts items, and for a start item orders the endpoints,
// picks the major axis and computes both deltas. Emits one command per item.
// ----------------------------------------------------------------------------
module blr_front #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
	localparam int CMD_W = 6 * COORD_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	blr_in_if.sink           in_ch,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output logic [CMD_W-1:0] cmd_data
);
	import blr_pkg::*;

	localparam int C = COORD_BITS;

	typedef struct packed {
		logic                kind;
		logic                steep;
		logic signed [C-1:0] cur_x;
		logic signed [C-1:0] cur_y;
		logic signed [C-1:0] fin_x;
		logic signed [C-1:0] fin_y;
		logic [C-1:0]        dmaj;
		logic [C-1:0]        dmin;
	} cmd_t;

	logic signed [C:0] diff_x;
	logic signed [C:0] diff_y;
	logic [C:0]        abs_x;
	logic [C:0]        abs_y;
	logic [C-1:0]      dx;
	logic [C-1:0]      dy;
	logic              steep;
	logic              swap;
	cmd_t              cmd_d;
	cmd_t              cmd_s1;
	logic              valid_s1;

	// endpoint differences, one bit wider than a coordinate
	assign diff_x = $signed({in_ch.end_x[C-1], in_ch.end_x})
		- $signed({in_ch.start_x[C-1], in_ch.start_x});
	assign diff_y = $signed({in_ch.end_y[C-1], in_ch.end_y})
		- $signed({in_ch.start_y[C-1], in_ch.start_y});
	assign abs_x  = diff_x[C] ? $unsigned(-diff_x) : $unsigned(diff_x);
	assign abs_y  = diff_y[C] ? $unsigned(-diff_y) : $unsigned(diff_y);
	assign dx     = abs_x[C-1:0];
	assign dy     = abs_y[C-1:0];

	// steep lines run along y; order the endpoints so the major axis rises
	assign steep = dy > dx;
	assign swap  = steep ? (in_ch.end_y < in_ch.start_y) : (in_ch.end_x < in_ch.start_x);

	// build the command
	always_comb begin
		cmd_d.kind  = in_ch.kind;
		cmd_d.steep = steep;
		cmd_d.cur_x = swap ? in_ch.end_x   : in_ch.start_x;
		cmd_d.cur_y = swap ? in_ch.end_y   : in_ch.start_y;
		cmd_d.fin_x = swap ? in_ch.start_x : in_ch.end_x;
		cmd_d.fin_y = swap ? in_ch.start_y : in_ch.end_y;
		cmd_d.dmaj  = steep ? dy : dx;
		cmd_d.dmin  = steep ? dx : dy;
	end

	// take a new item whenever the stage is empty or drains this cycle
	assign in_ch.ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// hold the command payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

endmodule

// File: rtl/blr_queue.sv
// ----------------------------------------------------------------------------
// blr_queue
// Short command queue between decode and stepping, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module blr_queue #(
	parameter int DATA_W = 6 * blr_pkg::COORD_BITS_DEF + 2,
	parameter int DEPTH  = blr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output logic [DATA_W-1:0] rd_data
);
	import blr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != CNT_FULL;
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// store an item at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_ONE)
		else $error("push without pop did not grow the queue");

	a_last_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push && count_q == CNT_ONE |=> !rd_valid)
		else $error("queue not empty after popping its only item");
`endif

endmodule

// File: rtl/blr_back.sv
// ----------------------------------------------------------------------------
// blr_back
// Stepping engine: loads a line on a start command and, on each step
// command, emits the current pixel and advances the Bresenham state.
// ----------------------------------------------------------------------------
module blr_back #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF,
	localparam int CMD_W = 6 * COORD_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  logic [CMD_W-1:0] cmd_data,
	blr_out_if.source        out_ch
);
	import blr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int DEC_W = COORD_BITS + 3;
	localparam logic [C-1:0] ONE = C'(1);

	typedef struct packed {
		logic                kind;
		logic                steep;
		logic signed [C-1:0] cur_x;
		logic signed [C-1:0] cur_y;
		logic signed [C-1:0] fin_x;
		logic signed [C-1:0] fin_y;
		logic [C-1:0]        dmaj;
		logic [C-1:0]        dmin;
	} cmd_t;

	cmd_t                    cmd;
	logic                    active_q;
	logic                    steep_q;
	logic signed [C-1:0]     cur_x_q;
	logic signed [C-1:0]     cur_y_q;
	logic signed [C-1:0]     fin_x_q;
	logic signed [C-1:0]     fin_y_q;
	logic [C-1:0]            dmaj_q;
	logic [C-1:0]            dmin_q;
	logic signed [DEC_W-1:0] decision_q;
	logic                    out_valid_q;
	logic signed [C-1:0]     pixel_x_q;
	logic signed [C-1:0]     pixel_y_q;
	logic                    last_q;

	logic                    out_free;
	logic                    pop;
	logic                    do_start;
	logic                    do_emit;
	logic signed [C-1:0]     maj;
	logic signed [C-1:0]     mnr;
	logic signed [C-1:0]     maj_end;
	logic signed [C-1:0]     mnr_end;
	logic signed [C-1:0]     maj_next;
	logic signed [C-1:0]     mnr_next;
	logic                    is_last;
	logic                    dec_pos;
	logic signed [DEC_W-1:0] twice_min;
	logic signed [DEC_W-1:0] twice_maj;
	logic signed [DEC_W-1:0] dec_next;
	logic signed [DEC_W-1:0] dec_init;

	assign cmd = cmd_t'(cmd_data);

	// start commands and idle steps never need the output register
	assign out_free  = !out_valid_q || out_ch.ready;
	assign cmd_ready = (cmd.kind == KIND_START) || !active_q || out_free;
	assign pop       = cmd_valid && cmd_ready;
	assign do_start  = pop && (cmd.kind == KIND_START);
	assign do_emit   = pop && (cmd.kind == KIND_STEP) && active_q;

	// pick major and minor axes
	assign maj     = steep_q ? cur_y_q : cur_x_q;
	assign mnr     = steep_q ? cur_x_q : cur_y_q;
	assign maj_end = steep_q ? fin_y_q : fin_x_q;
	assign mnr_end = steep_q ? fin_x_q : fin_y_q;
	assign is_last = maj >= maj_end;

	// next position and decision term
	assign dec_pos   = !decision_q[DEC_W-1];
	assign twice_min = $signed({2'b00, dmin_q, 1'b0});
	assign twice_maj = $signed({2'b00, dmaj_q, 1'b0});
	assign dec_next  = dec_pos ? decision_q + (twice_min - twice_maj)
		: decision_q + twice_min;
	assign maj_next  = maj + ONE;

	always_comb begin
		mnr_next = mnr;
		if (dec_pos) begin
			if (mnr < mnr_end) begin
				mnr_next = mnr + ONE;
			end else if (mnr > mnr_end) begin
				mnr_next = mnr - ONE;
			end
		end
	end

	assign dec_init = $signed({2'b00, cmd.dmin, 1'b0}) - $signed({3'b000, cmd.dmaj});

	// line state: load on start, advance on each emitted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (do_start) begin
			active_q <= 1'b1;
		end else if (do_emit && is_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			steep_q    <= cmd.steep;
			cur_x_q    <= cmd.cur_x;
			cur_y_q    <= cmd.cur_y;
			fin_x_q    <= cmd.fin_x;
			fin_y_q    <= cmd.fin_y;
			dmaj_q     <= cmd.dmaj;
			dmin_q     <= cmd.dmin;
			decision_q <= dec_init;
		end else if (do_emit && !is_last) begin
			cur_x_q    <= steep_q ? mnr_next : maj_next;
			cur_y_q    <= steep_q ? maj_next : mnr_next;
			decision_q <= dec_next;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			pixel_x_q <= cur_x_q;
			pixel_y_q <= cur_y_q;
			last_q    <= is_last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.pixel_x    = pixel_x_q;
	assign out_ch.pixel_y    = pixel_y_q;
	assign out_ch.last_pixel = last_q;

`ifndef NO_ASSERTIONS
	a_decision_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (decision_q >= -twice_maj) && (decision_q <= twice_min))
		else $error("decision term left its range");

	a_major_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> maj <= maj_end)
		else $error("major coordinate passed the line end");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		do_emit && is_last |=> !active_q && out_valid_q && last_q)
		else $error("final pixel did not close the line");
`endif

endmodule

// File: rtl/bresenham_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Integer Bresenham line rasterizer for all octants.
// ----------------------------------------------------------------------------
// A start item (kind 0) loads a line; each step item (kind 1) returns one
// pixel, with last_pixel set on the end point, after which the line is idle
// and further steps return nothing. A start replaces any line in progress.
// The block takes one item per clock and returns one pixel per clock when
// the pixel channel is ready. An item passes a decode register, a two-entry
// command queue and the stepping engine, whose output register sets the
// rate: one add, compare and increment per pixel.
module bresenham_line_rasterizer_top #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	blr_in_if.sink     in_ch,
	blr_out_if.source  out_ch
);
	import blr_pkg::*;

	localparam int CMD_W = 6 * COORD_BITS + 2;

	logic             f_valid;
	logic             f_ready;
	logic [CMD_W-1:0] f_data;
	logic             b_valid;
	logic             b_ready;
	logic [CMD_W-1:0] b_data;

	// decode and endpoint setup
	blr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd_data (f_data)
	);

	// decouple decode from stepping
	blr_queue #(
		.DATA_W(CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_data),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (b_data)
	);

	// stepping engine and pixel output
	blr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd_data (b_data),
		.out_ch   (out_ch)
	);

endmodule

// File: dv/bresenham_line_rasterizer_top_tb.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_tb
// Drives start and step items into the line rasterizer and checks every pixel
// against an in-bench Bresenham predictor. A short table covers idle steps,
// single-point lines, full-range endpoints, ties and steep lines. Random line
// sequences with noise follow, under random idling on both channels, one long
// receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_tb;
	import blr_pkg::*;

	localparam int CB        = COORD_BITS_DEF;
	localparam int WORK_GOAL = 400;
	localparam int MAX_CYC   = 300000;
	localparam int HOLD_CYC  = 80;
	localparam int SETTLE    = 20;

	typedef enum logic [1:0] {BY_MODEL, NO_PIXEL, FIXED_PIXEL} row_check_t;

	typedef struct packed {
		logic                 kind;
		logic signed [CB-1:0] start_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] end_y;
	} line_cmd_t;

	typedef struct packed {
		logic signed [CB-1:0] pixel_x;
		logic signed [CB-1:0] pixel_y;
		logic                 last_pixel;
	} pixel_t;

	typedef struct packed {
		logic                 kind;
		logic signed [CB-1:0] start_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] end_y;
		row_check_t           check;
		logic signed [CB-1:0] pixel_x;
		logic signed [CB-1:0] pixel_y;
		logic                 last_pixel;
	} dir_row_t;

	// directed items; a typed pixel only where it is plain from the line setup
	localparam dir_row_t PLAN [23] = '{
		// kind      sx      sy      ex      ey      check        px      py      last
		// step while idle after reset
		'{KIND_STEP,  -1,     -1,     -1,     -1,     NO_PIXEL,    0,      0,      1'b0},
		// single-point line
		'{KIND_START, 5,      -7,     5,      -7,     BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  32767,  32767,  -1,     -1,     FIXED_PIXEL, 5,      -7,     1'b1},
		'{KIND_STEP,  0,      0,      0,      0,      NO_PIXEL,    0,      0,      1'b0},
		// full-range diagonal, replaced before it ends
		'{KIND_START, -32768, -32768, 32767,  32767,  BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  -32768, 0,      32767,  0,      FIXED_PIXEL, -32768, -32768, 1'b0},
		'{KIND_STEP,  0,      -32768, 0,      32767,  BY_MODEL,    0,      0,      1'b0},
		// full-range horizontal, endpoints swapped so x rises
		'{KIND_START, 32767,  0,      -32768, 0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      FIXED_PIXEL, -32768, 0,      1'b0},
		// full-range vertical, steep with endpoints swapped so y rises
		'{KIND_START, 0,      32767,  0,      -32768, BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      FIXED_PIXEL, 0,      -32768, 1'b0},
		'{KIND_STEP,  -1,     -1,     -1,     -1,     BY_MODEL,    0,      0,      1'b0},
		// tie |dx| == |dy|: x stays major, run to the end
		'{KIND_START, 0,      0,      -3,     3,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		// steep line going down, run to the end and one step past it
		'{KIND_START, 1,      2,      0,      -1,     BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      BY_MODEL,    0,      0,      1'b0},
		'{KIND_STEP,  0,      0,      0,      0,      NO_PIXEL,    0,      0,      1'b0}
	};

	logic clk;
	logic arst_n;

	blr_in_if  #(.COORD_BITS(CB)) in_ch ();
	blr_out_if #(.COORD_BITS(CB)) out_ch ();

	bresenham_line_rasterizer_top #(.COORD_BITS(CB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// check mode that travels with the item on the input channel
	row_check_t drv_check;
	pixel_t     drv_px;

	pixel_t pixels_due [$];
	int     mismatches = 0;
	int     work_items = 0;
	int     cycles     = 0;
	bit     steady     = 1'b0;
	bit     hold_req   = 1'b0;

	// line state of the predictor
	logic                 ln_active = 1'b0;
	logic                 ln_steep  = 1'b0;
	logic signed [CB-1:0] ln_x      = '0;
	logic signed [CB-1:0] ln_y      = '0;
	logic signed [CB-1:0] ln_end_x  = '0;
	logic signed [CB-1:0] ln_end_y  = '0;
	logic [CB-1:0]        ln_major  = '0;
	logic [CB-1:0]        ln_minor  = '0;
	logic signed [CB+2:0] ln_err    = '0;

	// apply one item to the line state; return 1 when a pixel comes out
	function automatic bit rasterize(input line_cmd_t c, output pixel_t px);
		logic signed [CB:0]   ax, ay, bx, by, t;
		logic [CB-1:0]        adx, ady;
		logic signed [CB-1:0] maj, maj_end, mnr, mnr_end;
		bit                   done;
		px = '0;
		if (c.kind == KIND_START) begin
			ax = (CB+1)'(c.start_x);
			ay = (CB+1)'(c.start_y);
			bx = (CB+1)'(c.end_x);
			by = (CB+1)'(c.end_y);
			if (bx < ax) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			adx = CB'(bx - ax);
			ady = CB'((by > ay) ? by - ay : ay - by);
			ln_steep = ady > adx;
			// steep lines run with y rising
			if (ln_steep && by < ay) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			ln_major  = ln_steep ? ady : adx;
			ln_minor  = ln_steep ? adx : ady;
			ln_x      = ax[CB-1:0];
			ln_y      = ay[CB-1:0];
			ln_end_x  = bx[CB-1:0];
			ln_end_y  = by[CB-1:0];
			ln_err    = (CB+3)'(2 * int'(ln_minor) - int'(ln_major));
			ln_active = 1'b1;
			return 1'b0;
		end
		if (!ln_active)
			return 1'b0;
		px.pixel_x = ln_x;
		px.pixel_y = ln_y;
		maj     = ln_steep ? ln_y : ln_x;
		maj_end = ln_steep ? ln_end_y : ln_end_x;
		mnr     = ln_steep ? ln_x : ln_y;
		mnr_end = ln_steep ? ln_end_x : ln_end_y;
		done    = maj >= maj_end;
		px.last_pixel = done;
		if (done) begin
			ln_active = 1'b0;
			return 1'b1;
		end
		// advance major axis, minor one toward the end when the error allows
		maj = CB'(maj + 1);
		if (ln_err >= 0) begin
			ln_err = (CB+3)'(ln_err + 2 * (int'(ln_minor) - int'(ln_major)));
			if (mnr < mnr_end)
				mnr = CB'(mnr + 1);
			else if (mnr > mnr_end)
				mnr = CB'(mnr - 1);
		end else begin
			ln_err = (CB+3)'(ln_err + 2 * int'(ln_minor));
		end
		if (ln_steep) begin
			ln_y = maj;
			ln_x = mnr;
		end else begin
			ln_x = maj;
			ln_y = mnr;
		end
		return 1'b1;
	endfunction

	// item with every field random
	function automatic line_cmd_t any_cmd(input logic k);
		line_cmd_t c;
		c.kind    = k;
		c.start_x = CB'($urandom);
		c.start_y = CB'($urandom);
		c.end_x   = CB'($urandom);
		c.end_y   = CB'($urandom);
		return c;
	endfunction

	// offer one item, hold until accepted, then idle now and then
	task automatic offer(input line_cmd_t c, input row_check_t chk, input pixel_t px);
		in_ch.valid   <= 1'b1;
		in_ch.kind    <= c.kind;
		in_ch.start_x <= c.start_x;
		in_ch.start_y <= c.start_y;
		in_ch.end_x   <= c.end_x;
		in_ch.end_y   <= c.end_y;
		drv_check     <= chk;
		drv_px        <= px;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (!steady && $urandom_range(0, 99) < 8) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYC) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// track accepted items and check pixels
	always @(posedge clk) begin : track
		line_cmd_t c;
		pixel_t    px;
		pixel_t    want;
		bit        emitted;
		if (arst_n === 1'b1 && in_ch.valid && in_ch.ready) begin
			c = '{in_ch.kind, in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y};
			emitted = rasterize(c, px);
			if (c.kind == KIND_START || emitted)
				work_items++;
			case (drv_check)
				FIXED_PIXEL: pixels_due.push_back(drv_px);
				NO_PIXEL: ;
				default: begin
					if (emitted)
						pixels_due.push_back(px);
				end
			endcase
		end
		if (arst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel (%0d,%0d) last=%0b with none expected",
					out_ch.pixel_x, out_ch.pixel_y, out_ch.last_pixel);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				if (out_ch.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, out_ch.pixel_x);
					mismatches++;
				end
				if (out_ch.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, out_ch.pixel_y);
					mismatches++;
				end
				if (out_ch.last_pixel !== want.last_pixel) begin
					$error("last_pixel: expected %0b, got %0b",
						want.last_pixel, out_ch.last_pixel);
					mismatches++;
				end
			end
		end
	end

	// pixel receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				for (n = 0; n < HOLD_CYC; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end
			out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
		end
	end

	// reset, directed table, random line sequences, drain
	initial begin
		line_cmd_t c;
		pixel_t    nopx;
		int        bx, by, dx, dy, steps, i;
		bit        hold_done, pause_done;
		nopx       = '0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.kind    <= KIND_START;
		in_ch.start_x <= '0;
		in_ch.start_y <= '0;
		in_ch.end_x   <= '0;
		in_ch.end_y   <= '0;
		drv_check     <= BY_MODEL;
		drv_px        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (PLAN[r]) begin
			c = '{PLAN[r].kind, PLAN[r].start_x, PLAN[r].start_y, PLAN[r].end_x,
				PLAN[r].end_y};
			offer(c, PLAN[r].check,
				'{PLAN[r].pixel_x, PLAN[r].pixel_y, PLAN[r].last_pixel});
		end

		// random line sequences with some noise
		while (work_items < WORK_GOAL) begin
			steady = (work_items >= 300 && work_items < 360);
			if (!hold_done && work_items >= 150) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			// drain pause: lower valid and wait for every pixel
			if (!pause_done && work_items >= 250) begin
				pause_done = 1'b1;
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (pixels_due.size() != 0);
			end
			if ($urandom_range(0, 99) < 15) begin
				offer(any_cmd(1'($urandom_range(0, 1))), BY_MODEL, nopx);
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					// full-range endpoints: long line, cut short by the next start
					c = any_cmd(KIND_START);
					steps = $urandom_range(1, 6);
				end else begin
					bx = int'($urandom_range(0, 65495)) - 32748;
					by = int'($urandom_range(0, 65495)) - 32748;
					dx = int'($urandom_range(0, 40)) - 20;
					dy = int'($urandom_range(0, 40)) - 20;
					if ($urandom_range(0, 19) == 0) begin
						dx = 0;
						dy = 0;
					end
					c.kind    = KIND_START;
					c.start_x = CB'(bx);
					c.start_y = CB'(by);
					c.end_x   = CB'(bx + dx);
					c.end_y   = CB'(by + dy);
					steps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
						(dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy)) + 1;
					case ($urandom_range(0, 9))
						0: steps = $urandom_range(0, steps);
						1: steps = steps + $urandom_range(1, 2);
						default: ;
					endcase
				end
				offer(c, BY_MODEL, nopx);
				for (i = 0; i < steps; i++)
					offer(any_cmd(KIND_STEP), BY_MODEL, nopx);
			end
		end
		steady = 1'b0;

		// drain and let stray pixels show up
		in_ch.valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
